// ===== rtl/core/utf8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to code point decoder.
// No dependencies.
package utf8dec_pkg;

    localparam int unsigned CpWidth   = 22;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned OutTdataW = 24;

    localparam logic [CpWidth-1:0] QMARK_CP = CpWidth'(8'h3F);

    // lead byte classes
    localparam logic [3:0] LEAD4_PAT = 4'hF;
    localparam logic [2:0] LEAD3_PAT = 3'b111;
    localparam logic [1:0] LEAD2_PAT = 2'b11;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               last_of_item;
        logic               end_of_text;
    } t_result;

endpackage

// ===== rtl/core/utf8dec_step.sv =====
// Per-byte decode step: sequence state registers and result generation.
// Depends on utf8dec_pkg.
module utf8dec_step
    import utf8dec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [ByteWidth-1:0] i_byte,
    input  logic                 i_end,
    output logic [1:0]           o_count,
    output t_result              o_res0,
    output t_result              o_res1
);

    logic [1:0]         r_owed;
    logic [CpWidth-1:0] r_pv;
    logic [1:0]         n_owed;
    logic [CpWidth-1:0] n_pv;
    logic [CpWidth-1:0] w_cp0;
    logic [CpWidth-1:0] w_cp1;
    logic [1:0]         w_cnt;
    logic [CpWidth-1:0] w_ascii;

    assign w_ascii = CpWidth'(i_byte);

    always_comb begin
        n_owed = r_owed;
        n_pv   = r_pv;
        w_cnt  = 2'd0;
        w_cp0  = QMARK_CP;
        w_cp1  = QMARK_CP;
        if (r_owed != 2'd0) begin
            if (i_byte[7]) begin
                n_pv   = {r_pv[CpWidth-7:0], i_byte[5:0]};
                n_owed = r_owed - 2'd1;
                if (n_owed == 2'd0) begin
                    w_cnt = 2'd1;
                    w_cp0 = n_pv;
                    n_pv  = '0;
                end
            end else begin
                w_cnt  = 2'd2;
                w_cp0  = QMARK_CP;
                w_cp1  = w_ascii;
                n_owed = 2'd0;
                n_pv   = '0;
            end
        end else if (!i_byte[7]) begin
            w_cnt = 2'd1;
            w_cp0 = w_ascii;
        end else if (i_byte[7:4] == LEAD4_PAT) begin
            n_owed = 2'd3;
            n_pv   = CpWidth'(i_byte[3:0]);
        end else if (i_byte[7:5] == LEAD3_PAT) begin
            n_owed = 2'd2;
            n_pv   = CpWidth'(i_byte[3:0]);
        end else if (i_byte[7:6] == LEAD2_PAT) begin
            n_owed = 2'd1;
            n_pv   = CpWidth'(i_byte[4:0]);
        end
        // string ended inside a sequence
        if (i_end && n_owed != 2'd0) begin
            n_owed = 2'd0;
            n_pv   = '0;
            if (w_cnt == 2'd0) begin
                w_cp0 = QMARK_CP;
            end else begin
                w_cp1 = QMARK_CP;
            end
            w_cnt = w_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= 2'd0;
            r_pv   <= '0;
        end else if (i_accept) begin
            r_owed <= n_owed;
            r_pv   <= n_pv;
        end
    end

    assign o_count = w_cnt;
    assign o_res0  = '{code_point: w_cp0, last_of_item: (w_cnt == 2'd1), end_of_text: i_end};
    assign o_res1  = '{code_point: w_cp1, last_of_item: 1'b1, end_of_text: i_end};

endmodule

// ===== rtl/core/utf8_to_code_point_decoder_unit.sv =====
// Top level of the UTF-8 to code point decoder.
// Depends on utf8dec_pkg and utf8dec_step.
//
// Usage:
//   Slave stream carries one UTF-8 byte per beat in tdata, tlast marks the
//   final byte of a string. Master stream carries one code point per beat
//   in tdata, tuser flags the last result of the causing byte, tlast marks
//   results caused by the string's final byte.
//   The first result of an accepted byte shows on the master side in the
//   next cycle. Throughput: one byte per cycle while each byte yields at
//   most one result and the master side is ready; a byte that yields two
//   results (a broken sequence) holds the slave side until its second
//   result leaves the spare slot, as the master port moves one result per
//   beat. Bytes that yield no result (leads, continuations) clear the output.
//   An output register plus one spare slot for the second result decouple
//   the sides: a new byte is accepted while a result waits, as long as the
//   spare slot is empty and the output register frees up this cycle.
//   Reset clears the pending sequence and drops any queued results.
//   A master-side stall holds the result and backs up the slave side.
module utf8_to_code_point_decoder_unit
    import utf8dec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ByteWidth-1:0] i_s_tdata,   // [7:0] data_byte
    input  logic                 i_s_tlast,   // string_end
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OutTdataW-1:0] o_m_tdata,   // [21:0] code_point, [23:22] zero
    output logic                 o_m_tuser,   // last_of_item
    output logic                 o_m_tlast    // end_of_text
);

    logic       w_accept;
    logic       w_out_free;
    logic [1:0] w_count;
    t_result    w_res0;
    t_result    w_res1;
    t_result    r_out;
    t_result    r_pend;
    logic       r_out_vld;
    logic       r_pend_vld;

    assign w_out_free = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_pend_vld && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    utf8dec_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_tdata),
        .i_end    (i_s_tlast),
        .o_count  (w_count),
        .o_res0   (w_res0),
        .o_res1   (w_res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (w_accept) begin
            r_out_vld  <= (w_count != 2'd0);
            r_pend_vld <= (w_count == 2'd2);
            r_out      <= w_res0;
            r_pend     <= w_res1;
        end else if (r_pend_vld && w_out_free) begin
            r_out_vld  <= 1'b1;
            r_pend_vld <= 1'b0;
            r_out      <= r_pend;
        end else if (w_out_free) begin
            r_out_vld  <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OutTdataW'(r_out.code_point);
    assign o_m_tuser  = r_out.last_of_item;
    assign o_m_tlast  = r_out.end_of_text;

    a_pend_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_out_vld && !r_out.last_of_item && r_pend.last_of_item))
        else $error("second result queued without a non-final first result");

    a_no_accept_pend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> !o_s_tready)
        else $error("byte accepted while a second result is queued");

    a_pend_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_vld && i_m_tready) |=> (r_out_vld && !r_pend_vld && r_out.last_of_item))
        else $error("queued result not moved to output");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for utf8_to_code_point_decoder_unit: UTF-8 bytes in, code points out.
// A scoreboard class decodes each accepted byte and checks every result beat in order.
// Depends on utf8dec_pkg and the decoder RTL.
module tb;
    import utf8dec_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_BYTES = 1400;
    localparam int unsigned HOLD_CYCLES = 300;

    // {string_end, data_byte}
    localparam logic [8:0] OPENING [25] = '{
        9'h000, 9'h07F, 9'h141,                 // ASCII extremes, end on ASCII
        9'h0C3, 9'h0A9,                         // 2-byte
        9'h0E2, 9'h082, 9'h1AC,                 // 3-byte, end on final byte
        9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF,         // 4-byte, widest value
        9'h180,                                 // stray continuation with end
        9'h0C3, 9'h041,                         // broken sequence
        9'h1E2,                                 // lead alone at end
        9'h0E2, 9'h182,                         // truncated 3-byte
        9'h0E2, 9'h0F0, 9'h0C3,                 // lead bytes taken as continuations
        9'h0F0, 9'h09F, 9'h098, 9'h080          // 4-byte
    };

    class code_point_board;
        t_result            code_points_due[$];
        logic [1:0]         owed_bytes;
        logic [CpWidth-1:0] partial_cp;
        int                 mismatches;

        function new();
            owed_bytes = '0;
            partial_cp = '0;
            mismatches = 0;
        endfunction

        function void expect_cp(logic [CpWidth-1:0] cp, logic fin);
            t_result entry;
            entry = '{code_point: cp, last_of_item: 1'b0, end_of_text: fin};
            code_points_due.insert(code_points_due.size(), entry);
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            t_result tail;
            int      made;
            made = 0;
            if (owed_bytes != 0) begin
                if (b[7]) begin
                    partial_cp = {partial_cp[CpWidth-7:0], b[5:0]};
                    owed_bytes = owed_bytes - 2'd1;
                    if (owed_bytes == 0) begin
                        expect_cp(partial_cp, fin);
                        made++;
                        partial_cp = '0;
                    end
                end else begin
                    expect_cp(QMARK_CP, fin);
                    expect_cp(CpWidth'(b), fin);
                    made += 2;
                    owed_bytes = '0;
                    partial_cp = '0;
                end
            end else if (!b[7]) begin
                expect_cp(CpWidth'(b), fin);
                made++;
            end else if (b[7:4] == LEAD4_PAT) begin
                owed_bytes = 2'd3;
                partial_cp = CpWidth'(b[3:0]);
            end else if (b[7:5] == LEAD3_PAT) begin
                owed_bytes = 2'd2;
                partial_cp = CpWidth'(b[3:0]);
            end else if (b[7:6] == LEAD2_PAT) begin
                owed_bytes = 2'd1;
                partial_cp = CpWidth'(b[4:0]);
            end
            if (fin && owed_bytes != 0) begin
                expect_cp(QMARK_CP, fin);
                made++;
                owed_bytes = '0;
                partial_cp = '0;
            end
            if (made > 0) begin
                tail = code_points_due.pop_back();
                tail.last_of_item = 1'b1;
                code_points_due.insert(code_points_due.size(), tail);
            end
        endfunction

        task flag_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(logic [OutTdataW-1:0] tdata, logic tuser, logic tlast);
            t_result want;
            if (code_points_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat tdata=%h", tdata));
                return;
            end
            want = code_points_due.pop_front();
            if (tdata !== OutTdataW'(want.code_point))
                flag_mismatch($sformatf("tdata %h, want %h", tdata, want.code_point));
            if (tuser !== want.last_of_item)
                flag_mismatch($sformatf("tuser %b, want %b (cp %h)", tuser,
                                        want.last_of_item, want.code_point));
            if (tlast !== want.end_of_text)
                flag_mismatch($sformatf("tlast %b, want %b (cp %h)", tlast,
                                        want.end_of_text, want.code_point));
        endtask

        function int waiting();
            return code_points_due.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [ByteWidth-1:0] i_s_tdata = '0;
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [OutTdataW-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;

    code_point_board board;
    logic            calm = 1'b0;
    int              hold_seq = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    int              cycles = 0;
    int              counted = 0;

    utf8_to_code_point_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** utf8_to_code_point_decoder_unit: FAILED **");
            $finish;
        end
    end

    // result side: check beats, random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    task send_byte(logic [7:0] b, logic fin);
        while (!calm && $urandom_range(0, 99) < 24) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_byte(b, fin);
    endtask

    // mostly well-formed characters with random payload, some raw noise
    task send_random_char();
        int         pick;
        int         width;
        logic [7:0] b;
        logic       fin;
        pick = $urandom_range(0, 99);
        if (pick < 17) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            counted++;
            return;
        end
        if (pick < 50) begin
            width = 1;
            b = 8'($urandom_range(0, 127));
        end else if (pick < 70) begin
            width = 2;
            b = {3'b110, 5'($urandom_range(0, 31))};
        end else if (pick < 85) begin
            width = 3;
            b = {4'b1110, 4'($urandom_range(0, 15))};
        end else begin
            width = 4;
            b = {4'b1111, 4'($urandom_range(0, 15))};
        end
        for (int i = 0; i < width; i++) begin
            if (i > 0) begin
                if ($urandom_range(0, 29) == 0)
                    b = 8'($urandom_range(0, 127));
                else
                    b = {2'b10, 6'($urandom_range(0, 63))};
            end
            if (i == width - 1)
                fin = $urandom_range(0, 7) == 0;
            else
                fin = $urandom_range(0, 29) == 0;
            send_byte(b, fin);
            counted++;
        end
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (OPENING[k])
            send_byte(OPENING[k][7:0], OPENING[k][8]);
        while (counted < RANDOM_BYTES) begin
            calm <= (counted >= 500 && counted < 800);
            if (counted >= 200 && hold_seq == 0)
                hold_seq <= 1;
            send_random_char();
        end
        i_s_tvalid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("** utf8_to_code_point_decoder_unit: PASSED **");
        else
            $display("** utf8_to_code_point_decoder_unit: FAILED **");
        $finish;
    end

endmodule
